FILE: src/rgp_pkg.sv
// rgp_pkg: shared constants, stop codes and the stop pattern tables of the
// gradient palette. No dependencies; imported by every module in src.
package rgp_pkg;

    localparam int CHANNEL_BITS_DEF       = 8;
    localparam int POSITION_FRAC_BITS_DEF = 12;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_KIND   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_PATTERN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BACK_COLOUR  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FORE_COLOUR  = 3'd3;

    // blend kinds; the fourth code selects black
    localparam logic [1:0] BLEND_LINEAR = 2'd0;
    localparam logic [1:0] BLEND_SUM    = 2'd1;
    localparam logic [1:0] BLEND_SUB    = 2'd2;

    localparam int          PATTERN_COUNT = 9;
    localparam logic [3:0]  PATTERN_LAST  = 4'd8;
    localparam int          STOP_MAX      = 7;

    typedef enum logic [1:0] {
        STOP_BLACK = 2'd0,
        STOP_BACK  = 2'd1,
        STOP_FORE  = 2'd2
    } t_stop;

    // number of segments (stops - 1) per pattern
    localparam logic [2:0] STOP_SPAN [PATTERN_COUNT] = '{
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6
    };

    localparam t_stop STOP_LIST [PATTERN_COUNT][STOP_MAX] = '{
        '{STOP_BACK,  STOP_FORE,  STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK},
        '{STOP_BLACK, STOP_BACK,  STOP_FORE,  STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK},
        '{STOP_BACK,  STOP_FORE,  STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK},
        '{STOP_BACK,  STOP_BLACK, STOP_FORE,  STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK},
        '{STOP_BLACK, STOP_FORE,  STOP_BACK,  STOP_BLACK, STOP_BLACK, STOP_BLACK, STOP_BLACK},
        '{STOP_BACK,  STOP_FORE,  STOP_BACK,  STOP_FORE,  STOP_BLACK, STOP_BLACK, STOP_BLACK},
        '{STOP_BACK,  STOP_FORE,  STOP_BACK,  STOP_FORE,  STOP_BACK,  STOP_FORE,  STOP_BLACK},
        '{STOP_BLACK, STOP_BACK,  STOP_FORE,  STOP_BACK,  STOP_FORE,  STOP_BLACK, STOP_BLACK},
        '{STOP_BLACK, STOP_BACK,  STOP_FORE,  STOP_BACK,  STOP_FORE,  STOP_BACK,  STOP_FORE}
    };

    function automatic logic [2:0] stop_span(input logic [3:0] pattern);
        logic [2:0] span;
        span = 3'd1;
        if (pattern <= PATTERN_LAST) begin
            span = STOP_SPAN[pattern];
        end
        return span;
    endfunction

    function automatic t_stop stop_kind(input logic [3:0] pattern, input logic [2:0] idx);
        t_stop kind;
        kind = STOP_BLACK;
        if (pattern <= PATTERN_LAST) begin
            kind = STOP_LIST[pattern][idx];
        end
        return kind;
    endfunction

endpackage

FILE: src/rgp_segment.sv
// rgp_segment: first pipeline stage. Clamps the position, finds the segment
// and local position, and picks the two stop colours. Uses rgp_pkg.
module rgp_segment #(
    parameter int CHANNEL_BITS       = rgp_pkg::CHANNEL_BITS_DEF,
    parameter int POSITION_FRAC_BITS = rgp_pkg::POSITION_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [POSITION_FRAC_BITS:0]           i_position,
    input  logic [1:0]                            i_blend_kind,
    input  logic [3:0]                            i_stop_pattern,
    input  logic [3*CHANNEL_BITS-1:0]             i_back,
    input  logic [3*CHANNEL_BITS-1:0]             i_fore,
    output logic [2:0][CHANNEL_BITS-1:0]          o_left,
    output logic [2:0][CHANNEL_BITS-1:0]          o_right,
    output logic [POSITION_FRAC_BITS:0]           o_t,
    output logic [1:0]                            o_kind
);
    import rgp_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int PFB = POSITION_FRAC_BITS;
    localparam logic [PFB:0] POS_ONE = {1'b1, {PFB{1'b0}}};

    logic [PFB:0]   w_pos;
    logic [2:0]     w_span;
    logic [PFB+2:0] w_full;
    logic [2:0]     w_seg;
    logic [PFB+2:0] w_base;
    logic [PFB+2:0] w_tfull;
    logic           w_black;
    t_stop          w_lkind;
    t_stop          w_rkind;
    logic [2:0][CB-1:0] w_left;
    logic [2:0][CB-1:0] w_right;

    logic [2:0][CB-1:0] r_left;
    logic [2:0][CB-1:0] r_right;
    logic [PFB:0]       r_t;
    logic [1:0]         r_kind;

    function automatic logic [CB-1:0] pick(input t_stop kind, input logic [3*CB-1:0] back,
                                           input logic [3*CB-1:0] fore, input int chan);
        logic [CB-1:0] val;
        val = '0;
        case (kind)
            STOP_BACK: val = back[(2-chan)*CB +: CB];
            STOP_FORE: val = fore[(2-chan)*CB +: CB];
            default:   val = '0;
        endcase
        return val;
    endfunction

    always_comb begin
        w_pos   = (i_position > POS_ONE) ? POS_ONE : i_position;
        w_span  = stop_span(i_stop_pattern);
        w_full  = (PFB+3)'(w_pos) * (PFB+3)'(w_span);
        w_seg   = w_full[PFB+2:PFB];
        if (w_seg > w_span - 3'd1) begin
            w_seg = w_span - 3'd1;
        end
        w_base  = {w_seg, {PFB{1'b0}}};
        w_tfull = w_full - w_base;
        w_lkind = stop_kind(i_stop_pattern, w_seg);
        w_rkind = stop_kind(i_stop_pattern, w_seg + 3'd1);
        w_black = (i_stop_pattern > PATTERN_LAST) || (i_blend_kind > BLEND_SUB);
        for (int k = 0; k < 3; k++) begin
            w_left[k]  = w_black ? '0 : pick(w_lkind, i_back, i_fore, k);
            w_right[k] = w_black ? '0 : pick(w_rkind, i_back, i_fore, k);
        end
    end

    // black case travels as a linear blend of two black stops
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= w_left;
            r_right <= w_right;
            r_t     <= w_tfull[PFB:0];
            r_kind  <= w_black ? BLEND_LINEAR : i_blend_kind;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_t     = r_t;
    assign o_kind  = r_kind;

endmodule

FILE: src/rgp_mid.sv
// rgp_mid: middle colour of the segment. One prep stage, then a restoring
// divider with one quotient bit per stage for the scaled-sum case. Uses rgp_pkg.
module rgp_mid #(
    parameter int CHANNEL_BITS       = rgp_pkg::CHANNEL_BITS_DEF,
    parameter int POSITION_FRAC_BITS = rgp_pkg::POSITION_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic [CHANNEL_BITS:0]                 i_en,
    input  logic [2:0][CHANNEL_BITS-1:0]          i_left,
    input  logic [2:0][CHANNEL_BITS-1:0]          i_right,
    input  logic [POSITION_FRAC_BITS:0]           i_t,
    input  logic [1:0]                            i_kind,
    output logic [2:0][CHANNEL_BITS-1:0]          o_left,
    output logic [2:0][CHANNEL_BITS-1:0]          o_right,
    output logic [2:0][CHANNEL_BITS-1:0]          o_mid,
    output logic [POSITION_FRAC_BITS:0]           o_t,
    output logic [1:0]                            o_kind
);
    import rgp_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int PFB = POSITION_FRAC_BITS;
    localparam int NW  = 2*CB + 1;
    localparam logic [CB:0] CH_MAX = {1'b0, {CB{1'b1}}};

    // prep stage
    logic [2:0][CB:0]   w_sum;
    logic [CB:0]        w_smax;
    logic [2:0][CB-1:0] w_sub;
    logic [2:0][NW-1:0] w_num;

    logic [2:0][NW-1:0] r_num;
    logic [CB:0]        r_den;
    logic [2:0][CB-1:0] r_pl, r_pr, r_palt;
    logic [PFB:0]       r_pt;
    logic [1:0]         r_pkind;
    logic               r_puse;

    // divider stages; index 0 of the source arrays is the prep stage
    logic [2:0][NW-1:0] w_srem [CB+1];
    logic [2:0][CB-1:0] w_squo [CB+1];
    logic [CB:0]        w_sden [CB+1];
    logic [2:0][NW-1:0] n_rem  [CB];
    logic [2:0][CB-1:0] n_quo  [CB];
    logic [NW-1:0]      w_dsh  [CB];

    logic [2:0][NW-1:0] r_rem  [CB];
    logic [2:0][CB-1:0] r_quo  [CB];
    logic [CB:0]        r_dden [CB];
    logic [2:0][CB-1:0] r_l    [CB];
    logic [2:0][CB-1:0] r_r    [CB];
    logic [2:0][CB-1:0] r_alt  [CB];
    logic [PFB:0]       r_t    [CB];
    logic [1:0]         r_kind [CB];
    logic               r_use  [CB];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = {1'b0, i_left[k]} + {1'b0, i_right[k]};
            w_sub[k] = (i_right[k] > i_left[k]) ? (i_right[k] - i_left[k]) : '0;
        end
        w_smax = w_sum[0];
        if (w_sum[1] > w_smax) w_smax = w_sum[1];
        if (w_sum[2] > w_smax) w_smax = w_sum[2];
        // s*M + smax/2, with M = 2^CB - 1
        for (int k = 0; k < 3; k++) begin
            w_num[k] = NW'({w_sum[k], {CB{1'b0}}}) - NW'(w_sum[k]) + NW'(w_smax[CB:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num   <= w_num;
            r_den   <= w_smax;
            r_pl    <= i_left;
            r_pr    <= i_right;
            for (int k = 0; k < 3; k++) begin
                r_palt[k] <= (i_kind == BLEND_SUM) ? w_sum[k][CB-1:0] : w_sub[k];
            end
            r_pt    <= i_t;
            r_pkind <= i_kind;
            r_puse  <= (i_kind == BLEND_SUM) && (w_smax > CH_MAX);
        end
    end

    always_comb begin
        w_srem[0] = r_num;
        w_squo[0] = '0;
        w_sden[0] = r_den;
        for (int j = 0; j < CB; j++) begin
            w_srem[j+1] = r_rem[j];
            w_squo[j+1] = r_quo[j];
            w_sden[j+1] = r_dden[j];
        end
        // stage j settles quotient bit CB-1-j
        for (int j = 0; j < CB; j++) begin
            w_dsh[j] = NW'(w_sden[j]) << (CB - 1 - j);
            for (int k = 0; k < 3; k++) begin
                if (w_srem[j][k] >= w_dsh[j]) begin
                    n_rem[j][k] = w_srem[j][k] - w_dsh[j];
                    n_quo[j][k] = {w_squo[j][k][CB-2:0], 1'b1};
                end else begin
                    n_rem[j][k] = w_srem[j][k];
                    n_quo[j][k] = {w_squo[j][k][CB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CB; j++) begin
            if (i_en[j+1]) begin
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
                r_dden[j] <= w_sden[j];
                if (j == 0) begin
                    r_l[j]    <= r_pl;
                    r_r[j]    <= r_pr;
                    r_alt[j]  <= r_palt;
                    r_t[j]    <= r_pt;
                    r_kind[j] <= r_pkind;
                    r_use[j]  <= r_puse;
                end else begin
                    r_l[j]    <= r_l[j-1];
                    r_r[j]    <= r_r[j-1];
                    r_alt[j]  <= r_alt[j-1];
                    r_t[j]    <= r_t[j-1];
                    r_kind[j] <= r_kind[j-1];
                    r_use[j]  <= r_use[j-1];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_mid[k] = r_use[CB-1] ? r_quo[CB-1][k] : r_alt[CB-1][k];
        end
    end

    assign o_left  = r_l[CB-1];
    assign o_right = r_r[CB-1];
    assign o_t     = r_t[CB-1];
    assign o_kind  = r_kind[CB-1];

endmodule

FILE: src/rgp_blend.sv
// rgp_blend: half selection and interpolation, three stages
// (select, multiply, round). Uses rgp_pkg.
module rgp_blend #(
    parameter int CHANNEL_BITS       = rgp_pkg::CHANNEL_BITS_DEF,
    parameter int POSITION_FRAC_BITS = rgp_pkg::POSITION_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic [2:0]                            i_en,
    input  logic [2:0][CHANNEL_BITS-1:0]          i_left,
    input  logic [2:0][CHANNEL_BITS-1:0]          i_right,
    input  logic [2:0][CHANNEL_BITS-1:0]          i_mid,
    input  logic [POSITION_FRAC_BITS:0]           i_t,
    input  logic [1:0]                            i_kind,
    output logic [2:0][CHANNEL_BITS-1:0]          o_colour
);
    import rgp_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int PFB = POSITION_FRAC_BITS;
    localparam int PW  = CB + PFB + 3;
    localparam logic [PFB+1:0] POS_ONE_W = {2'b01, {PFB{1'b0}}};
    localparam logic [PFB:0]   POS_HALF  = {2'b01, {(PFB-1){1'b0}}};

    logic [PFB+1:0]     w_t2;
    logic [PFB+1:0]     w_t2m;
    logic [2:0][CB-1:0] r_a, r_b;
    logic [PFB:0]       r_tt;

    logic signed [CB:0]    w_diff [3];
    logic signed [PFB+1:0] w_tts;
    logic signed [PW-1:0]  r_prod [3];
    logic [2:0][CB-1:0]    r_a2;

    logic signed [PW-1:0] w_acc [3];
    logic [2:0][CB-1:0]   r_colour;

    assign w_t2  = {i_t, 1'b0};
    assign w_t2m = w_t2 - POS_ONE_W;

    // select: linear uses the whole segment, the other kinds one half of it
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            if (i_kind == BLEND_LINEAR) begin
                r_a  <= i_left;
                r_b  <= i_right;
                r_tt <= i_t;
            end else if (i_t < POS_HALF) begin
                r_a  <= i_left;
                r_b  <= i_mid;
                r_tt <= w_t2[PFB:0];
            end else begin
                r_a  <= i_mid;
                r_b  <= i_right;
                r_tt <= w_t2m[PFB:0];
            end
        end
    end

    // a*(P-t) + b*t = a*P + (b-a)*t
    assign w_tts = $signed({1'b0, r_tt});
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = $signed({1'b0, r_b[k]}) - $signed({1'b0, r_a[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= w_diff[k] * w_tts;
            end
            r_a2 <= r_a;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_acc[k] = $signed({3'b000, r_a2[k], {PFB{1'b0}}}) + r_prod[k]
                     + $signed(PW'(POS_HALF));
        end
    end

    // the rounded result never exceeds full scale
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_colour[k] <= w_acc[k][PFB +: CB];
            end
        end
    end

    assign o_colour = r_colour;

endmodule

FILE: src/rgp_gamma.sv
// rgp_gamma: squaring gamma step, round(c*c / M) with M = 2^CB - 1.
// Two stages: square, then divide by M with one correction. Uses rgp_pkg.
module rgp_gamma #(
    parameter int CHANNEL_BITS = rgp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic [1:0]                   i_en,
    input  logic [2:0][CHANNEL_BITS-1:0] i_colour,
    output logic [2:0][CHANNEL_BITS-1:0] o_gamma
);
    import rgp_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam logic [CB:0]     CH_MAX  = {1'b0, {CB{1'b1}}};
    localparam logic [2*CB-1:0] HALF_MAX = {{(CB+1){1'b0}}, {(CB-1){1'b1}}};

    logic [2*CB-1:0] r_sq [3];
    logic [2*CB-1:0] w_x  [3];
    logic [CB-1:0]   w_q0 [3];
    logic [CB:0]     w_rem [3];
    logic [2:0][CB-1:0] r_gamma;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= (2*CB)'(i_colour[k]) * (2*CB)'(i_colour[k]);
            end
        end
    end

    // x/M: x>>CB is at most one short, since x = q0*M + (low + q0)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_x[k]   = r_sq[k] + HALF_MAX;
            w_q0[k]  = w_x[k][2*CB-1:CB];
            w_rem[k] = {1'b0, w_x[k][CB-1:0]} + {1'b0, w_q0[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r_gamma[k] <= w_q0[k] + CB'(w_rem[k] >= CH_MAX);
            end
        end
    end

    assign o_gamma = r_gamma;

endmodule

FILE: src/rgb_gradient_palette.sv
// rgb_gradient_palette: top level. Configuration registers, pipeline valid
// and enable control; instantiates rgp_segment, rgp_mid, rgp_blend, rgp_gamma.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  position | in        | i_valid / o_ready    | i_position
//  colour   | out       | o_valid / i_ready    | o_red_out, o_green_out, o_blue_out
//  config   | in        | i_cfg_we (no wait)   | i_cfg_index, i_cfg_data
//
// One request per clock while o_ready is high; the bit-per-stage divider for the
// scaled-sum middle colour sets the pipeline depth.
// Reset is synchronous, active low; clears valid bits and config, fore to ones.
// Each stage holds while the stages after it are full and the output is not
// taken, so bubbles close up; o_ready drops only when every stage is full.
module rgb_gradient_palette #(
    parameter int CHANNEL_BITS       = rgp_pkg::CHANNEL_BITS_DEF,
    parameter int POSITION_FRAC_BITS = rgp_pkg::POSITION_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [POSITION_FRAC_BITS:0]           i_position,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [CHANNEL_BITS-1:0]               o_red_out,
    output logic [CHANNEL_BITS-1:0]               o_green_out,
    output logic [CHANNEL_BITS-1:0]               o_blue_out,
    input  logic                                  i_cfg_we,
    input  logic [rgp_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [3*CHANNEL_BITS-1:0]             i_cfg_data
);
    import rgp_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int PFB = POSITION_FRAC_BITS;
    // segment, prep, CB divider stages, select, multiply, round, square, output
    localparam int NST      = CB + 7;
    localparam int ST_MID   = 1;
    localparam int ST_BLEND = CB + 2;
    localparam int ST_GAMMA = CB + 5;

    // configuration registers
    logic [1:0]       r_blend_kind;
    logic [3:0]       r_stop_pattern;
    logic [3*CB-1:0]  r_back;
    logic [3*CB-1:0]  r_fore;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_kind   <= BLEND_LINEAR;
            r_stop_pattern <= '0;
            r_back         <= '0;
            r_fore         <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BLEND_KIND:   r_blend_kind   <= i_cfg_data[1:0];
                REG_STOP_PATTERN: r_stop_pattern <= i_cfg_data[3:0];
                REG_BACK_COLOUR:  r_back         <= i_cfg_data;
                REG_FORE_COLOUR:  r_fore         <= i_cfg_data;
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // pipeline control: a stage loads when it is empty or some later stage
    // has room (or the output is being taken)
    logic [NST-1:0] r_valid;
    logic [NST-1:0] n_valid;
    logic [NST-1:0] w_en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = i_ready || !(&r_valid[NST-1:k]);
    end

    assign n_valid = (w_en & {r_valid[NST-2:0], i_valid}) | (~w_en & r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_valid[NST-1];

    // datapath
    logic [2:0][CB-1:0] w_seg_left, w_seg_right;
    logic [PFB:0]       w_seg_t;
    logic [1:0]         w_seg_kind;
    logic [2:0][CB-1:0] w_mid_left, w_mid_right, w_mid_mid;
    logic [PFB:0]       w_mid_t;
    logic [1:0]         w_mid_kind;
    logic [2:0][CB-1:0] w_colour;
    logic [2:0][CB-1:0] w_gamma;

    rgp_segment #(
        .CHANNEL_BITS       (CB),
        .POSITION_FRAC_BITS (PFB)
    ) u_segment (
        .i_clk          (i_clk),
        .i_en           (w_en[0]),
        .i_position     (i_position),
        .i_blend_kind   (r_blend_kind),
        .i_stop_pattern (r_stop_pattern),
        .i_back         (r_back),
        .i_fore         (r_fore),
        .o_left         (w_seg_left),
        .o_right        (w_seg_right),
        .o_t            (w_seg_t),
        .o_kind         (w_seg_kind)
    );

    rgp_mid #(
        .CHANNEL_BITS       (CB),
        .POSITION_FRAC_BITS (PFB)
    ) u_mid (
        .i_clk   (i_clk),
        .i_en    (w_en[ST_MID +: CB+1]),
        .i_left  (w_seg_left),
        .i_right (w_seg_right),
        .i_t     (w_seg_t),
        .i_kind  (w_seg_kind),
        .o_left  (w_mid_left),
        .o_right (w_mid_right),
        .o_mid   (w_mid_mid),
        .o_t     (w_mid_t),
        .o_kind  (w_mid_kind)
    );

    rgp_blend #(
        .CHANNEL_BITS       (CB),
        .POSITION_FRAC_BITS (PFB)
    ) u_blend (
        .i_clk    (i_clk),
        .i_en     (w_en[ST_BLEND +: 3]),
        .i_left   (w_mid_left),
        .i_right  (w_mid_right),
        .i_mid    (w_mid_mid),
        .i_t      (w_mid_t),
        .i_kind   (w_mid_kind),
        .o_colour (w_colour)
    );

    rgp_gamma #(
        .CHANNEL_BITS (CB)
    ) u_gamma (
        .i_clk    (i_clk),
        .i_en     (w_en[ST_GAMMA +: 2]),
        .i_colour (w_colour),
        .o_gamma  (w_gamma)
    );

    assign o_red_out   = w_gamma[0];
    assign o_green_out = w_gamma[1];
    assign o_blue_out  = w_gamma[2];

`ifndef SYNTH
    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid[0])
        else $error("accepted request missing from first stage");

    // back pressure reaches the input only with every stage full
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_valid))
        else $error("input stalled while the pipeline has a bubble");

    // a held output stays held, payload included
    a_output_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable({o_red_out, o_green_out, o_blue_out})))
        else $error("stalled output changed");

    // pattern writes land in the register
    a_pattern_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == REG_STOP_PATTERN) |=>
            (r_stop_pattern == $past(i_cfg_data[3:0])))
        else $error("stop pattern write lost");
`endif

endmodule
